>>> sv/two_class_priority_queue_core_defines.svh
// ----------------------------------------------------------------------------
// Two-class priority queue: assertion macros
// Shared property forms for the queue core's checks.
// ----------------------------------------------------------------------------
`ifndef TWO_CLASS_PRIORITY_QUEUE_CORE_DEFINES_SVH
`define TWO_CLASS_PRIORITY_QUEUE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset
`define TCPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define TCPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// Two-class priority queue package
// Payload types, codes and control structs shared by the queue core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tcpq_pkg;

  localparam int CODE_W            = 16;
  localparam int DEF_QUEUE_DEPTH   = 16;
  localparam int DEF_CODE_BITS     = 16;

  typedef enum logic {
    CMD_ARRIVE = 1'b0,
    CMD_SERVE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_STORED  = 2'd0,
    STAT_DROPPED = 2'd1,
    STAT_SERVED  = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t              command;
    logic [CODE_W-1:0] client_code;
    logic              is_preferred;
  } req_t;

  typedef struct packed {
    status_t           status;
    logic [CODE_W-1:0] served_code;
    logic              served_preferred;
  } rsp_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic do_arrive;   // arrival transfer this cycle
    logic do_serve_rd; // serve transfer: pick class, launch store read
    logic do_serve_wb; // store data ready: load the result register
    logic rsp_pop;     // result transfer this cycle
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic rsp_valid;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> sv/tcpq_ctrl.sv
// ----------------------------------------------------------------------------
// Two-class priority queue controller
// Accepts requests and sequences the datapath through arrival and serve.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcpq_ctrl
  import tcpq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    req_valid,
  input  wire cmd_t    req_command,
  output logic         req_ready,
  input  wire logic    rsp_ready,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        slot_free;
  logic        req_xfer;

  // result register is free, or empties at this edge
  assign slot_free = !sts.rsp_valid || rsp_ready;
  assign req_xfer  = req_valid && req_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_xfer && req_command == CMD_SERVE) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    req_ready       = 1'b0;
    cmd.do_arrive   = 1'b0;
    cmd.do_serve_rd = 1'b0;
    cmd.do_serve_wb = 1'b0;
    cmd.rsp_pop     = sts.rsp_valid && rsp_ready;
    unique case (state)
      S_IDLE: begin
        req_ready       = slot_free;
        cmd.do_arrive   = req_valid && slot_free && req_command == CMD_ARRIVE;
        cmd.do_serve_rd = req_valid && slot_free && req_command == CMD_SERVE;
      end
      S_READ: begin
        cmd.do_serve_wb = 1'b1;
      end
      default: begin
        req_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/tcpq_dp.sv
// ----------------------------------------------------------------------------
// Two-class priority queue datapath
// Per-class ring stores, pointers, occupancy and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tcpq_dp
  import tcpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int CODE_BITS   = DEF_CODE_BITS
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire req_t    req,
  input  wire dp_cmd_t cmd,
  output dp_sts_t      sts,
  output logic         rsp_valid,
  output rsp_t         rsp
);

  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int STORE_W = (CODE_BITS < CODE_W) ? CODE_BITS : CODE_W;

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W:0]   CAPACITY = (CNT_W + 1)'(QUEUE_DEPTH);

  logic [STORE_W-1:0] pref_mem [QUEUE_DEPTH];
  logic [STORE_W-1:0] reg_mem  [QUEUE_DEPTH];
  logic [STORE_W-1:0] pref_rd;
  logic [STORE_W-1:0] reg_rd;

  logic [PTR_W-1:0] pref_head;
  logic [PTR_W-1:0] pref_tail;
  logic [PTR_W-1:0] reg_head;
  logic [PTR_W-1:0] reg_tail;
  logic [CNT_W-1:0] pref_count;
  logic [CNT_W-1:0] reg_count;

  logic sel_hit;
  logic sel_pref;

  logic full;
  logic wr_pref;
  logic wr_reg;
  logic rd_pref;
  logic rd_reg;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] idx);
    return (idx == PTR_LAST) ? '0 : idx + PTR_W'(1);
  endfunction

  assign full    = ({1'b0, pref_count} + {1'b0, reg_count}) >= CAPACITY;
  assign wr_pref = cmd.do_arrive && !full && req.is_preferred;
  assign wr_reg  = cmd.do_arrive && !full && !req.is_preferred;
  // preferred class always wins a serve
  assign rd_pref = cmd.do_serve_rd && (pref_count != '0);
  assign rd_reg  = cmd.do_serve_rd && (pref_count == '0) && (reg_count != '0);

  assign sts.rsp_valid = rsp_valid;

  // ring stores: one write, one registered read per class
  always_ff @(posedge clk) begin
    if (wr_pref) begin
      pref_mem[pref_tail] <= req.client_code[STORE_W-1:0];
    end
    if (cmd.do_serve_rd) begin
      pref_rd <= pref_mem[pref_head];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_reg) begin
      reg_mem[reg_tail] <= req.client_code[STORE_W-1:0];
    end
    if (cmd.do_serve_rd) begin
      reg_rd <= reg_mem[reg_head];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pref_head  <= '0;
      pref_tail  <= '0;
      reg_head   <= '0;
      reg_tail   <= '0;
      pref_count <= '0;
      reg_count  <= '0;
    end else begin
      if (wr_pref) begin
        pref_tail  <= ring_next(pref_tail);
        pref_count <= pref_count + CNT_W'(1);
      end
      if (wr_reg) begin
        reg_tail  <= ring_next(reg_tail);
        reg_count <= reg_count + CNT_W'(1);
      end
      if (rd_pref) begin
        pref_head  <= ring_next(pref_head);
        pref_count <= pref_count - CNT_W'(1);
      end
      if (rd_reg) begin
        reg_head  <= ring_next(reg_head);
        reg_count <= reg_count - CNT_W'(1);
      end
    end
  end

  // remember which class the pending serve took
  always_ff @(posedge clk) begin
    if (cmd.do_serve_rd) begin
      sel_hit  <= rd_pref || rd_reg;
      sel_pref <= rd_pref;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.do_arrive || cmd.do_serve_wb) begin
      rsp_valid <= 1'b1;
    end else if (cmd.rsp_pop) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_arrive) begin
      rsp.status           <= full ? STAT_DROPPED : STAT_STORED;
      rsp.served_code      <= '0;
      rsp.served_preferred <= 1'b0;
    end else if (cmd.do_serve_wb) begin
      if (sel_hit) begin
        rsp.status           <= STAT_SERVED;
        rsp.served_code      <= CODE_W'(sel_pref ? pref_rd : reg_rd);
        rsp.served_preferred <= sel_pref;
      end else begin
        rsp.status           <= STAT_EMPTY;
        rsp.served_code      <= '0;
        rsp.served_preferred <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/two_class_priority_queue_core.sv
// ----------------------------------------------------------------------------
// Two-class priority queue core
// Preferred clients leave before regular ones; each class is first in,
// first out; both classes share QUEUE_DEPTH entries.
//
//   Channel | Direction | Handshake              | Payload
//   req     | in        | req_valid / req_ready  | req_t (command, code, class)
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_t (status, code, class)
//
// An arrival's store write and result load happen at the same edge.
// In a serve, the per-class store read is registered before the
// result register loads.
// req_ready drops while a serve read is in flight or the result is held.
// rst is synchronous: both rings empty, no result pending; stores not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "two_class_priority_queue_core_defines.svh"

module two_class_priority_queue_core
  import tcpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int CODE_BITS   = DEF_CODE_BITS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output logic      req_ready,
  input  wire req_t req,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  tcpq_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_command (req.command),
    .req_ready   (req_ready),
    .rsp_ready   (rsp_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  tcpq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .CODE_BITS   (CODE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  `TCPQ_ASSERT_NEXT(a_serve_in_flight, req_valid && req_ready && req.command == CMD_SERVE, !req_ready && !rsp_valid, "serve transfer did not hold off the request side")
  `TCPQ_ASSERT_NEXT(a_arrive_result, req_valid && req_ready && req.command == CMD_ARRIVE, rsp_valid && (rsp.status == STAT_STORED || rsp.status == STAT_DROPPED), "arrival gave no stored or dropped result")
  `TCPQ_ASSERT_NOW(a_unserved_zero, rsp_valid && rsp.status != STAT_SERVED, rsp.served_code == '0 && !rsp.served_preferred, "non-served result carries a client")

endmodule

`default_nettype wire
